FILE: hdl/lcf_pkg.sv
// Shared types and constants for the linear layer chain forward block.
// Used by lcf_mac and by the top level; depends on nothing else.
package lcf_pkg;

	// operation field codes
	localparam logic OP_WEIGHT = 1'b0;
	localparam logic OP_FEED   = 1'b1;

	// port width of weights and activations, fraction bits of Q4.12
	localparam int W_BITS    = 16;
	localparam int FRAC_BITS = 12;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_EMIT
	} lcf_state_t;

	// control that rides along with each operand pair into the MAC
	typedef struct packed {
		logic vld;
		logic first;
		logic last;
	} lcf_mac_ctrl_t;

endpackage

FILE: hdl/lcf_wmem.sv
// Weight store: one write port, one read port with registered read data.
// No dependencies.
module lcf_wmem #(
	parameter int DEPTH = 300,
	parameter int AW    = 9,
	parameter int DW    = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic signed [DW-1:0] wdata,
	input  logic [AW-1:0]        raddr,
	output logic signed [DW-1:0] rdata
);

	logic signed [DW-1:0] mem [DEPTH];
	logic signed [DW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[raddr];
	end

	assign rdata = rd_data_q;

endmodule

FILE: hdl/lcf_mac.sv
// Shared multiply-accumulate unit: product stage, accumulate stage, then
// round-half-up to Q4.12 and saturate on the write-back path. Uses lcf_pkg.
module lcf_mac #(
	parameter int DATA_BITS = 16,
	parameter int WIDTH     = 10,
	parameter int IDX_W     = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lcf_pkg::lcf_mac_ctrl_t      ctrl_s1,
	input  logic [IDX_W-1:0]            row_s1,
	input  logic signed [DATA_BITS-1:0] act_s1,
	input  logic signed [lcf_pkg::W_BITS-1:0] wgt_s1,
	output logic                        busy,
	output logic                        wb_vld,
	output logic [IDX_W-1:0]            wb_row,
	output logic signed [DATA_BITS-1:0] wb_value
);

	localparam int PROD_W = DATA_BITS + lcf_pkg::W_BITS;
	localparam int ACC_W  = PROD_W + $clog2(WIDTH);
	localparam int SH_W   = ACC_W - lcf_pkg::FRAC_BITS;
	localparam logic signed [ACC_W-1:0] ROUND_HALF =
		ACC_W'(1) <<< (lcf_pkg::FRAC_BITS - 1);
	localparam logic signed [SH_W-1:0] DMAX =
		{{(SH_W - DATA_BITS + 1){1'b0}}, {(DATA_BITS - 1){1'b1}}};
	localparam logic signed [SH_W-1:0] DMIN = ~DMAX;

	lcf_pkg::lcf_mac_ctrl_t      ctrl_s2;
	logic [IDX_W-1:0]            row_s2;
	logic signed [PROD_W-1:0]    prod_s2;
	logic                        done_s3;
	logic [IDX_W-1:0]            row_s3;
	logic signed [ACC_W-1:0]     acc_q;
	logic signed [ACC_W-1:0]     rnd;
	logic signed [SH_W-1:0]      shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
			done_s3 <= 1'b0;
		end else begin
			ctrl_s2 <= ctrl_s1;
			done_s3 <= ctrl_s2.vld & ctrl_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= act_s1 * wgt_s1;
		row_s2  <= row_s1;
		row_s3  <= row_s2;
		if (ctrl_s2.vld) begin
			// restart the sum on the first column of each row
			if (ctrl_s2.first) begin
				acc_q <= ACC_W'(prod_s2);
			end else begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
		end
	end

	always_comb begin
		rnd     = acc_q + ROUND_HALF;
		shifted = SH_W'(rnd >>> lcf_pkg::FRAC_BITS);
		if (shifted > DMAX) begin
			wb_value = DATA_BITS'(DMAX);
		end else if (shifted < DMIN) begin
			wb_value = DATA_BITS'(DMIN);
		end else begin
			wb_value = DATA_BITS'(shifted);
		end
	end

	assign busy   = ctrl_s2.vld | done_s3;
	assign wb_vld = done_s3;
	assign wb_row = row_s3;

endmodule

FILE: hdl/linear_layer_chain_forward.sv
// Top level of the linear layer chain forward block: sequencer, ping-pong
// activation buffers and output register. Uses lcf_pkg, lcf_wmem and lcf_mac.

// A weight beat writes one Q4.12 weight; a feed beat stores one input element.
// The feed beat that completes a vector of WIDTH elements starts a forward
// pass: one shared multiply-accumulate unit walks every layer row by row, one
// product per cycle, and waits for the MAC pipeline to empty before the next
// layer reads the new activations. The pass is followed by WIDTH result
// beats, the last one marked by last. in_ready is low from the completing
// feed beat until the final result has been loaded into the output register.
// Weights never written read as undefined values.
module linear_layer_chain_forward #(
	parameter int LAYERS    = 3,
	parameter int WIDTH     = 10,
	parameter int DATA_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               operation,
	input  logic [1:0]         layer_index,
	input  logic [3:0]         neuron_index,
	input  logic [3:0]         weight_index,
	input  logic signed [15:0] weight_value,
	input  logic signed [15:0] activation_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] output_value,
	output logic [3:0]         output_index,
	output logic               last
);

	localparam int DEPTH = LAYERS * WIDTH * WIDTH;
	localparam int WA_W  = $clog2(DEPTH);
	localparam int IDX_W = $clog2(WIDTH);
	localparam int LYR_W = (LAYERS > 1) ? $clog2(LAYERS) : 1;
	localparam logic signed [32:0] DHI = (33'sd1 <<< (DATA_BITS - 1)) - 33'sd1;
	localparam logic signed [32:0] DLO = -DHI - 33'sd1;

	function automatic logic signed [32:0] clamp_data(input logic signed [15:0] v);
		logic signed [32:0] e;
		e = 33'(v);
		if (e > DHI) begin
			return DHI;
		end else if (e < DLO) begin
			return DLO;
		end
		return e;
	endfunction

	lcf_pkg::lcf_state_t state_q, state_d;

	logic [IDX_W-1:0] cnt_q;
	logic [IDX_W-1:0] col_q;
	logic [IDX_W-1:0] row_q;
	logic [LYR_W-1:0] layer_q;
	logic [WA_W-1:0]  wa_q;

	logic signed [DATA_BITS-1:0] buf_q [2][WIDTH];

	logic in_fire;
	logic issue;
	logic issue_end;
	logic pipe_empty;
	logic drain_done;
	logic layer_end;
	logic emit_load;
	logic rd_bank;
	logic src_bank;
	logic signed [DATA_BITS-1:0] act_rd;

	lcf_pkg::lcf_mac_ctrl_t      ctrl_s0, ctrl_s1;
	logic [IDX_W-1:0]            row_s1;
	logic signed [DATA_BITS-1:0] act_s1;
	logic signed [lcf_pkg::W_BITS-1:0] wgt_s1;

	logic                        mac_busy;
	logic                        wb_vld;
	logic [IDX_W-1:0]            wb_row;
	logic signed [DATA_BITS-1:0] wb_value;

	logic                        w_we;
	logic [WA_W-1:0]             w_waddr;
	logic signed [lcf_pkg::W_BITS-1:0] w_wdata;

	logic                        out_valid_q;
	logic signed [15:0]          output_value_q;
	logic [3:0]                  output_index_q;
	logic                        last_q;

	assign in_fire = in_valid & in_ready;

	// weight write path
	always_comb begin
		w_we = in_fire && operation == lcf_pkg::OP_WEIGHT
			&& 32'(layer_index) < LAYERS
			&& 32'(neuron_index) < WIDTH
			&& 32'(weight_index) < WIDTH;
		w_waddr = WA_W'((32'(layer_index) * WIDTH + 32'(neuron_index)) * WIDTH
			+ 32'(weight_index));
		w_wdata = lcf_pkg::W_BITS'(clamp_data(weight_value));
	end

	lcf_wmem #(
		.DEPTH (DEPTH),
		.AW    (WA_W),
		.DW    (lcf_pkg::W_BITS)
	) u_wmem (
		.clk   (clk),
		.we    (w_we),
		.waddr (w_waddr),
		.wdata (w_wdata),
		.raddr (wa_q),
		.rdata (wgt_s1)
	);

	assign src_bank   = layer_q[0];
	assign pipe_empty = !ctrl_s1.vld && !mac_busy;
	assign layer_end  = layer_q == LYR_W'(LAYERS - 1);
	assign issue_end  = col_q == IDX_W'(WIDTH - 1) && row_q == IDX_W'(WIDTH - 1);
	// emit reads the destination bank of the last layer
	assign rd_bank    = (state_q == lcf_pkg::ST_EMIT) ? ~src_bank : src_bank;
	assign act_rd     = buf_q[rd_bank][col_q];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lcf_pkg::ST_IDLE: begin
				if (in_fire && operation == lcf_pkg::OP_FEED
					&& cnt_q == IDX_W'(WIDTH - 1)) begin
					state_d = lcf_pkg::ST_RUN;
				end
			end
			lcf_pkg::ST_RUN: begin
				if (issue_end) begin
					state_d = lcf_pkg::ST_DRAIN;
				end
			end
			lcf_pkg::ST_DRAIN: begin
				if (pipe_empty) begin
					state_d = layer_end ? lcf_pkg::ST_EMIT : lcf_pkg::ST_RUN;
				end
			end
			lcf_pkg::ST_EMIT: begin
				if (emit_load && col_q == IDX_W'(WIDTH - 1)) begin
					state_d = lcf_pkg::ST_IDLE;
				end
			end
			default: state_d = lcf_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready   = 1'b0;
		issue      = 1'b0;
		drain_done = 1'b0;
		emit_load  = 1'b0;
		case (state_q)
			lcf_pkg::ST_IDLE:  in_ready   = 1'b1;
			lcf_pkg::ST_RUN:   issue      = 1'b1;
			lcf_pkg::ST_DRAIN: drain_done = pipe_empty;
			lcf_pkg::ST_EMIT:  emit_load  = !out_valid_q || out_ready;
			default: ;
		endcase
		ctrl_s0.vld   = issue;
		ctrl_s0.first = col_q == '0;
		ctrl_s0.last  = col_q == IDX_W'(WIDTH - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lcf_pkg::ST_IDLE;
			cnt_q       <= '0;
			col_q       <= '0;
			row_q       <= '0;
			layer_q     <= '0;
			wa_q        <= '0;
			ctrl_s1     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ctrl_s1 <= ctrl_s0;
			if (in_fire && operation == lcf_pkg::OP_FEED) begin
				if (cnt_q == IDX_W'(WIDTH - 1)) begin
					cnt_q   <= '0;
					col_q   <= '0;
					row_q   <= '0;
					layer_q <= '0;
					wa_q    <= '0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (issue) begin
				wa_q <= wa_q + 1'b1;
				if (col_q == IDX_W'(WIDTH - 1)) begin
					col_q <= '0;
					row_q <= (row_q == IDX_W'(WIDTH - 1)) ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			if (drain_done && !layer_end) begin
				layer_q <= layer_q + 1'b1;
			end
			if (emit_load) begin
				out_valid_q <= 1'b1;
				col_q       <= (col_q == IDX_W'(WIDTH - 1)) ? '0 : col_q + 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		act_s1 <= act_rd;
		row_s1 <= row_q;
		if (in_fire && operation == lcf_pkg::OP_FEED) begin
			buf_q[0][cnt_q] <= DATA_BITS'(clamp_data(activation_value));
		end
		if (wb_vld) begin
			buf_q[~src_bank][wb_row] <= wb_value;
		end
		if (emit_load) begin
			output_value_q <= 16'(act_rd);
			output_index_q <= 4'(col_q);
			last_q         <= col_q == IDX_W'(WIDTH - 1);
		end
	end

	lcf_mac #(
		.DATA_BITS (DATA_BITS),
		.WIDTH     (WIDTH),
		.IDX_W     (IDX_W)
	) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl_s1  (ctrl_s1),
		.row_s1   (row_s1),
		.act_s1   (act_s1),
		.wgt_s1   (wgt_s1),
		.busy     (mac_busy),
		.wb_vld   (wb_vld),
		.wb_row   (wb_row),
		.wb_value (wb_value)
	);

	assign out_valid    = out_valid_q;
	assign output_value = output_value_q;
	assign output_index = output_index_q;
	assign last         = last_q;

`ifndef SYNTHESIS
	// the MAC pipeline is empty whenever new beats are taken
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!ctrl_s1.vld && !mac_busy))
		else $error("MAC busy while input is accepted");

	// write-back only lands during a layer pass
	a_wb_window: assert property (@(posedge clk) disable iff (!arst_n)
		wb_vld |-> (state_q == lcf_pkg::ST_RUN || state_q == lcf_pkg::ST_DRAIN))
		else $error("write-back outside layer pass");

	// emission starts at element zero
	a_emit_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == lcf_pkg::ST_EMIT) |-> col_q == '0)
		else $error("emit index not zero at start");
`endif

endmodule
